[design/pffa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffa_pkg
// Shared types and constants of the page fault frame allocator: field widths,
// status and command codes, register indexes and the queued request format.
// ----------------------------------------------------------------------------
package pffa_pkg;

	localparam int PAGE_W       = 6;
	localparam int FRAME_W      = 4;
	localparam int REQ_W        = 22;
	localparam int STATUS_W     = 3;
	localparam int COUNT_W      = 32;
	localparam int PAGES_CFG_W  = 7;
	localparam int FRAMES_CFG_W = 5;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;

	localparam logic [PAGES_CFG_W-1:0]  PAGES_CFG_RST  = 7'd64;
	localparam logic [FRAMES_CFG_W-1:0] FRAMES_CFG_RST = 5'd16;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	typedef enum logic [STATUS_W-1:0] {
		ST_FREE     = 3'd0,
		ST_CLEAN    = 3'd1,
		ST_DIRTY    = 3'd2,
		ST_RESIDENT = 3'd3,
		ST_MARKED   = 3'd4,
		ST_BAD      = 3'd5
	} status_t;

	typedef enum logic {
		CMD_FAULT = 1'b0,
		CMD_MARK  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAGES  = 1'b0,
		CFG_FRAMES = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_LOOK,
		BK_EVICT
	} back_state_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [PAGE_W-1:0]   page;
		logic [REQ_W-1:0]    requester;
		logic [FRAME_W-1:0]  victim;
		logic                page_ok;
		logic                victim_ok;
		logic                frames_ok;
	} item_t;

endpackage
`default_nettype wire

[design/pffa_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffa_front
// Request intake: range checks against the page and frame limits, then a
// short queue that hands classified requests to the back end.
// ----------------------------------------------------------------------------
module pffa_front #(
	parameter int MAX_PAGES  = 64,
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               command,
	input  wire logic [pffa_pkg::PAGE_W-1:0]        page,
	input  wire logic [pffa_pkg::REQ_W-1:0]         requester,
	input  wire logic [pffa_pkg::FRAME_W-1:0]       victim_frame,
	input  wire logic [pffa_pkg::PAGES_CFG_W-1:0]   pages_in_use,
	input  wire logic [pffa_pkg::FRAMES_CFG_W-1:0]  frames_in_use,
	output logic                                    q_valid,
	output pffa_pkg::item_t                         q_head,
	input  wire logic                               q_pop
);
	import pffa_pkg::*;

	item_t            q_mem_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    cnt_q;
	item_t            classified;
	logic             push;

	always_comb begin
		classified.cmd       = cmd_t'(command);
		classified.page      = page;
		classified.requester = requester;
		classified.victim    = victim_frame;
		classified.page_ok   = ({1'b0, page} < pages_in_use) && (32'(page) < MAX_PAGES);
		classified.victim_ok = ({1'b0, victim_frame} < frames_in_use)
			&& (32'(victim_frame) < MAX_FRAMES);
		classified.frames_ok = frames_in_use != '0;
	end

	assign in_ready = cnt_q != (Q_AW+1)'(Q_DEPTH);
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != '0;
	assign q_head   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_AW'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_AW'(1);
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + (Q_AW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[design/pffa_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pffa_back
// Fault handling sequencer: looks up the page and frame tables, places or
// evicts pages, keeps the disk access count and drives the result register.
// ----------------------------------------------------------------------------
module pffa_back #(
	parameter int MAX_PAGES  = 64,
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               q_valid,
	input  wire pffa_pkg::item_t                    q_head,
	output logic                                    q_pop,
	input  wire logic [pffa_pkg::FRAMES_CFG_W-1:0]  frames_in_use,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [pffa_pkg::STATUS_W-1:0]           status,
	output logic [pffa_pkg::FRAME_W-1:0]            frame,
	output logic [pffa_pkg::PAGE_W-1:0]             evicted_page,
	output logic [pffa_pkg::REQ_W-1:0]              resume_target,
	output logic [pffa_pkg::COUNT_W-1:0]            disk_accesses
);
	import pffa_pkg::*;

	localparam int PW = $clog2(MAX_PAGES);
	localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int KW = $clog2(MAX_FRAMES + 1);

	back_state_t           state_q;
	back_state_t           state_d;
	item_t                 cur_q;
	logic [FW-1:0]         ptf_rd_q;
	logic [PW-1:0]         ftp_rd_q;
	logic                  mod_rd_q;

	logic [FW-1:0]         ptf_mem [MAX_PAGES];
	logic [PW-1:0]         ftp_mem [MAX_FRAMES];
	logic                  mod_mem [MAX_PAGES];

	logic [MAX_PAGES-1:0]  resident_q;
	logic [MAX_PAGES-1:0]  resident_d;
	logic [KW-1:0]         fill_q;
	logic [COUNT_W-1:0]    count_q;

	logic                  out_valid_q;
	status_t               status_q;
	logic [FRAME_W-1:0]    frame_q;
	logic [PAGE_W-1:0]     evicted_q;
	logic [REQ_W-1:0]      resume_q;
	logic [COUNT_W-1:0]    disk_q;

	logic                  out_free;
	logic                  done;
	logic                  free_avail;
	logic                  fault_ok;
	logic [PW-1:0]         pidx;
	logic [FW-1:0]         target_free;
	logic [FW-1:0]         target_vic;
	logic [FW-1:0]         map_target;
	logic                  map_we;
	logic                  mod_we;
	logic                  mod_wd;
	logic                  mod_rd_en;
	logic                  res_clr;
	logic                  fill_inc;
	logic [1:0]            inc;
	logic [COUNT_W:0]      sum;
	logic [COUNT_W-1:0]    count_d;
	status_t               res_status;
	logic [FRAME_W-1:0]    res_frame;
	logic [PAGE_W-1:0]     res_evicted;

	assign pidx        = PW'(cur_q.page);
	assign target_free = FW'(fill_q);
	assign target_vic  = FW'(cur_q.victim);
	assign free_avail  = (32'(fill_q) < 32'(frames_in_use)) && (32'(fill_q) < MAX_FRAMES);
	assign fault_ok    = cur_q.page_ok && (cur_q.cmd == CMD_FAULT) && cur_q.frames_ok;
	assign out_free    = !out_valid_q || out_ready;

	always_comb begin
		state_d     = state_q;
		q_pop       = 1'b0;
		done        = 1'b0;
		mod_rd_en   = 1'b0;
		mod_we      = 1'b0;
		mod_wd      = 1'b0;
		map_we      = 1'b0;
		map_target  = target_free;
		res_clr     = 1'b0;
		fill_inc    = 1'b0;
		inc         = 2'd0;
		res_status  = ST_BAD;
		res_frame   = '0;
		res_evicted = '0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				if (cur_q.page_ok && resident_q[pidx]) begin
					res_frame = FRAME_W'(ptf_rd_q);
					if (cur_q.cmd == CMD_MARK) begin
						res_status = ST_MARKED;
						mod_we     = out_free;
						mod_wd     = 1'b1;
					end else begin
						res_status = ST_RESIDENT;
					end
					done = out_free;
				end else if (fault_ok && free_avail) begin
					res_status = ST_FREE;
					res_frame  = FRAME_W'(target_free);
					map_we     = out_free;
					mod_we     = out_free;
					fill_inc   = out_free;
					inc        = 2'd1;
					done       = out_free;
				end else if (fault_ok && cur_q.victim_ok) begin
					mod_rd_en = 1'b1;
					state_d   = BK_EVICT;
				end else begin
					done = out_free;
				end
				if (done) begin
					state_d = BK_IDLE;
				end
			end
			BK_EVICT: begin
				res_evicted = PAGE_W'(ftp_rd_q);
				res_frame   = FRAME_W'(target_vic);
				res_status  = mod_rd_q ? ST_DIRTY : ST_CLEAN;
				inc         = mod_rd_q ? 2'd2 : 2'd1;
				map_target  = target_vic;
				map_we      = out_free;
				mod_we      = out_free;
				res_clr     = out_free;
				done        = out_free;
				if (done) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// saturating disk access count
	always_comb begin
		sum     = {1'b0, count_q} + (COUNT_W+1)'(inc);
		count_d = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
	end

	// evicted page leaves, placed page arrives
	always_comb begin
		resident_d = resident_q;
		if (res_clr) begin
			resident_d[ftp_rd_q] = 1'b0;
		end
		if (map_we) begin
			resident_d[pidx] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q    <= q_head;
			ptf_rd_q <= ptf_mem[PW'(q_head.page)];
			ftp_rd_q <= ftp_mem[FW'(q_head.victim)];
		end
		if (mod_rd_en) begin
			mod_rd_q <= mod_mem[ftp_rd_q];
		end
		if (mod_we) begin
			mod_mem[pidx] <= mod_wd;
		end
		if (map_we) begin
			ptf_mem[pidx]       <= map_target;
			ftp_mem[map_target] <= pidx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resident_q <= '0;
			fill_q     <= '0;
			count_q    <= '0;
		end else begin
			resident_q <= resident_d;
			if (fill_inc) begin
				fill_q <= fill_q + KW'(1);
			end
			if (done) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q  <= res_status;
			frame_q   <= res_frame;
			evicted_q <= res_evicted;
			resume_q  <= cur_q.requester;
			disk_q    <= count_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign frame         = frame_q;
	assign evicted_page  = evicted_q;
	assign resume_target = resume_q;
	assign disk_accesses = disk_q;

endmodule
`default_nettype wire

[design/page_fault_frame_allocator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// page_fault_frame_allocator_top
// Page fault handler over a page table and a frame table with externally
// chosen victims, plus the two configuration registers.
// ----------------------------------------------------------------------------
// A taken request passes the queue, the lookup state and, on an eviction, the evict
//   state before the result register is loaded; the back end sequencer handles one
//   request at a time around its registered table reads
// reset: queue, sequencer, residency bits, fill count and disk count cleared,
//   configuration back to 64 pages and 16 frames; no clearing pass
module page_fault_frame_allocator_top #(
	parameter int MAX_PAGES  = 64,
	parameter int MAX_FRAMES = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             command,
	input  wire logic [pffa_pkg::PAGE_W-1:0]      page,
	input  wire logic [pffa_pkg::REQ_W-1:0]       requester,
	input  wire logic [pffa_pkg::FRAME_W-1:0]     victim_frame,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [pffa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pffa_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [pffa_pkg::STATUS_W-1:0]         status,
	output logic [pffa_pkg::FRAME_W-1:0]          frame,
	output logic [pffa_pkg::PAGE_W-1:0]           evicted_page,
	output logic [pffa_pkg::REQ_W-1:0]            resume_target,
	output logic [pffa_pkg::COUNT_W-1:0]          disk_accesses
);
	import pffa_pkg::*;

	logic [PAGES_CFG_W-1:0]   pages_in_use_q;
	logic [FRAMES_CFG_W-1:0]  frames_in_use_q;
	logic                     q_valid;
	logic                     q_pop;
	item_t                    q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_in_use_q  <= PAGES_CFG_RST;
			frames_in_use_q <= FRAMES_CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PAGES:  pages_in_use_q  <= cfg_data[PAGES_CFG_W-1:0];
				CFG_FRAMES: frames_in_use_q <= cfg_data[FRAMES_CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pffa_front #(
		.MAX_PAGES  (MAX_PAGES),
		.MAX_FRAMES (MAX_FRAMES)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.page          (page),
		.requester     (requester),
		.victim_frame  (victim_frame),
		.pages_in_use  (pages_in_use_q),
		.frames_in_use (frames_in_use_q),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop)
	);

	pffa_back #(
		.MAX_PAGES  (MAX_PAGES),
		.MAX_FRAMES (MAX_FRAMES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.frames_in_use (frames_in_use_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.frame         (frame),
		.evicted_page  (evicted_page),
		.resume_target (resume_target),
		.disk_accesses (disk_accesses)
	);

	// disk count never goes backwards from one result to the next
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || (disk_accesses >= $past(disk_accesses)))
		else $error("disk access count decreased");

	// a rejected request carries no frame
	a_bad_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD) |-> frame == '0)
		else $error("bad status with nonzero frame");

	// evicted page only reported on an eviction
	a_evicted_only_on_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_CLEAN) && (status != ST_DIRTY) |-> evicted_page == '0)
		else $error("evicted page without eviction");

	// queue pops only when the front end holds a request
	a_pop_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
`default_nettype wire

[bench/page_fault_frame_allocator_top_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// page_fault_frame_allocator_top_test
// Self-checking bench for the page fault frame allocator. A scoreboard keeps
// its own page and frame tables and predicts status, frame, evicted page,
// resume target and disk count for every accepted request. The stimulus is a
// short directed run over the special cases, then random faults and dirty
// marks under a series of register settings. These include zero pages, zero
// frames and values above the table sizes. The sender and the receiver both
// stall at random, and a long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module page_fault_frame_allocator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pffa_pkg::*;

	localparam int N_PAGES     = 64;
	localparam int N_FRAMES    = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;
	localparam int N_PHASES    = 11;
	localparam int PHASE_ITEMS = 130;

	typedef struct packed {
		status_t              status;
		logic [FRAME_W-1:0]   frame;
		logic [PAGE_W-1:0]    evicted;
		logic [REQ_W-1:0]     resume;
		logic [COUNT_W-1:0]   disk;
	} outcome_t;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SLOW,
		RX_PERIODIC
	} rx_mode_t;

	class paging_predictor;
		int unsigned pages_reg = PAGES_CFG_RST;
		int unsigned frames_reg = FRAMES_CFG_RST;
		bit resident[N_PAGES];
		bit [FRAME_W-1:0] frame_of[N_PAGES];
		bit dirty[N_PAGES];
		bit used[N_FRAMES];
		bit [PAGE_W-1:0] page_of[N_FRAMES];
		bit [COUNT_W-1:0] disk_count;
		outcome_t expected_outcomes[$];
		int status_tally[6];
		int reg_writes;
		int mismatches;
		int unexpected;
		int reported;

		function void write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_PAGES) begin
				pages_reg = data;
			end else begin
				frames_reg = data[FRAMES_CFG_W-1:0];
			end
			reg_writes++;
		endfunction

		function void count_access();
			if (disk_count != '1) begin
				disk_count++;
			end
		endfunction

		function void note_request(cmd_t cmd, logic [PAGE_W-1:0] pg, logic [REQ_W-1:0] req,
			logic [FRAME_W-1:0] vic);
			int np;
			int nf;
			int target;
			int old;
			outcome_t o;
			np = pages_reg > N_PAGES ? N_PAGES : pages_reg;
			nf = frames_reg > N_FRAMES ? N_FRAMES : frames_reg;
			o.status = ST_BAD;
			o.frame = '0;
			o.evicted = '0;
			o.resume = req;
			if (pg < np) begin
				if (resident[pg]) begin
					o.frame = frame_of[pg];
					if (cmd == CMD_MARK) begin
						dirty[pg] = 1'b1;
						o.status = ST_MARKED;
					end else begin
						o.status = ST_RESIDENT;
					end
				end else if (cmd == CMD_FAULT && nf > 0) begin
					target = nf;
					for (int f = nf - 1; f >= 0; f--) begin
						if (!used[f]) begin
							target = f;
						end
					end
					if (target < nf) begin
						o.status = ST_FREE;
						used[target] = 1'b1;
					end else if (vic < nf) begin
						target = vic;
						old = page_of[vic];
						o.evicted = page_of[vic];
						if (dirty[old]) begin
							o.status = ST_DIRTY;
							count_access();
						end else begin
							o.status = ST_CLEAN;
						end
						resident[old] = 1'b0;
						dirty[old] = 1'b0;
						frame_of[old] = '0;
					end
					if (o.status != ST_BAD) begin
						page_of[target] = pg;
						resident[pg] = 1'b1;
						frame_of[pg] = FRAME_W'(target);
						dirty[pg] = 1'b0;
						o.frame = FRAME_W'(target);
						count_access();
					end
				end
			end
			o.disk = disk_count;
			status_tally[o.status]++;
			expected_outcomes.push_back(o);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [FRAME_W-1:0] fr,
			logic [PAGE_W-1:0] ev, logic [REQ_W-1:0] rs, logic [COUNT_W-1:0] dc);
			outcome_t o;
			if (expected_outcomes.size() == 0) begin
				unexpected++;
				if (reported < 10) begin
					reported++;
					$display("tb: unexpected result at %0t: status %0d frame %0d evicted %0d",
						$time, st, fr, ev);
				end
			end else begin
				o = expected_outcomes.pop_front();
				if (st !== o.status || fr !== o.frame || ev !== o.evicted ||
					rs !== o.resume || dc !== o.disk) begin
					mismatches++;
					if (reported < 10) begin
						reported++;
						$display("tb: mismatch at %0t: expected status %0d frame %0d evicted %0d",
							$time, o.status, o.frame, o.evicted);
						$display("tb:   resume %h disk %0d; got status %0d frame %0d evicted %0d",
							o.resume, o.disk, st, fr, ev);
						$display("tb:   resume %h disk %0d", rs, dc);
					end
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic command = 1'b0;
	logic [PAGE_W-1:0] page = '0;
	logic [REQ_W-1:0] requester = '0;
	logic [FRAME_W-1:0] victim_frame = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0] frame;
	logic [PAGE_W-1:0] evicted_page;
	logic [REQ_W-1:0] resume_target;
	logic [COUNT_W-1:0] disk_accesses;

	paging_predictor predictor;
	bit hold_off_req;
	int burst_left;
	int cur_pages = PAGES_CFG_RST;
	int cur_frames = FRAMES_CFG_RST;
	int cfg_writes;
	int quiet_cycles;

	page_fault_frame_allocator_top #(
		.MAX_PAGES(N_PAGES),
		.MAX_FRAMES(N_FRAMES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.page(page),
		.requester(requester),
		.victim_frame(victim_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.frame(frame),
		.evicted_page(evicted_page),
		.resume_target(resume_target),
		.disk_accesses(disk_accesses)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				predictor.write_register(cfg_idx_t'(cfg_index), cfg_data);
			end
			if (in_valid && in_ready) begin
				predictor.note_request(cmd_t'(command), page, requester, victim_frame);
			end
			if (out_valid && out_ready) begin
				predictor.check_result(status, frame, evicted_page, resume_target, disk_accesses);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: no progress for %0d cycles, %0d results outstanding",
					quiet_cycles, predictor.expected_outcomes.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result side stall pattern, with an occasional long hold-off on request
	initial begin
		rx_mode_t rx_mode;
		int mode_left;
		int hold_left;
		int phase_cnt;
		rx_mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		phase_cnt = 0;
		forever begin
			@(posedge clk);
			phase_cnt++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 150);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN: out_ready <= 1'b1;
					RX_COIN: out_ready <= 1'($urandom_range(0, 1));
					RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (phase_cnt % 5) < 3;
				endcase
			end
		end
	end

	task automatic set_registers(int pages_val, int frames_val);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_PAGES;
		cfg_data <= CFG_DATA_W'(pages_val);
		do @(posedge clk); while (!cfg_ready);
		// upper data bits are ignored for the frame count
		cfg_index <= CFG_FRAMES;
		cfg_data <= CFG_DATA_W'(((cfg_writes % 4) << FRAMES_CFG_W) | frames_val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		cur_pages = pages_val > N_PAGES ? N_PAGES : pages_val;
		cur_frames = frames_val > N_FRAMES ? N_FRAMES : frames_val;
	endtask

	task automatic send_request(cmd_t c, logic [PAGE_W-1:0] pg, logic [REQ_W-1:0] rq,
		logic [FRAME_W-1:0] vc);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command <= c;
		page <= pg;
		requester <= rq;
		victim_frame <= vc;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (predictor.expected_outcomes.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_random(int n);
		cmd_t c;
		logic [PAGE_W-1:0] pg;
		logic [REQ_W-1:0] rq;
		logic [FRAME_W-1:0] vc;
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: rq = '0;
				1: rq = '1;
				default: rq = REQ_W'($urandom);
			endcase
			pg = (cur_pages > 0) ? PAGE_W'($urandom_range(0, cur_pages - 1)) : PAGE_W'($urandom);
			if (cur_frames > 0 && $urandom_range(0, 6) != 0) begin
				vc = FRAME_W'($urandom_range(0, cur_frames - 1));
			end else begin
				vc = FRAME_W'($urandom);
			end
			if (pick < 55) begin
				c = CMD_FAULT;
			end else if (pick < 80) begin
				c = CMD_MARK;
				// lean toward pages that are mapped so marks land
				for (int t = 0; t < 8 && cur_pages > 0 && !predictor.resident[pg]; t++) begin
					pg = PAGE_W'($urandom_range(0, cur_pages - 1));
				end
			end else if (pick < 90) begin
				c = CMD_FAULT;
				pg = PAGE_W'($urandom);
				vc = FRAME_W'($urandom);
			end else begin
				c = CMD_MARK;
				pg = PAGE_W'($urandom);
			end
			send_request(c, pg, rq, vc);
		end
	endtask

	initial begin
		int phase_pages[N_PHASES];
		int phase_frames[N_PHASES];
		int total;
		phase_pages = '{8, 1, 127, 16, 0, 30, 64, 12, 20, 64, 40};
		phase_frames = '{2, 1, 4, 0, 5, 8, 1, 3, 31, 16, 12};
		predictor = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two frames: free loads, hits, marks, both kinds of eviction, bad victims
		set_registers(64, 2);
		send_request(CMD_FAULT, 0, '0, 0);
		send_request(CMD_FAULT, 63, '1, 15);
		send_request(CMD_FAULT, 0, 22'h2AAAAA, 0);
		send_request(CMD_MARK, 0, 22'h155555, 0);
		send_request(CMD_MARK, 5, 22'd1, 0);
		send_request(CMD_FAULT, 5, 22'd2, 0);
		send_request(CMD_FAULT, 7, 22'd3, 1);
		send_request(CMD_FAULT, 9, 22'd4, 2);
		send_request(CMD_FAULT, 63, 22'd5, 15);
		send_request(CMD_MARK, 7, 22'd6, 0);
		wait_idle();
		// pages out of range and no frames at all
		set_registers(10, 0);
		send_request(CMD_FAULT, 10, 22'd7, 0);
		send_request(CMD_MARK, 63, 22'd8, 0);
		send_request(CMD_FAULT, 9, 22'd9, 0);
		send_request(CMD_FAULT, 5, 22'd10, 0);
		send_request(CMD_MARK, 5, 22'd11, 0);
		wait_idle();
		// register values above the table sizes
		set_registers(127, 31);
		send_request(CMD_FAULT, 9, 22'd12, 0);
		send_request(CMD_FAULT, 7, 22'd13, 0);
		send_request(CMD_FAULT, 40, 22'd14, 3);
		send_request(CMD_FAULT, 5, 22'd15, 0);
		wait_idle();
		set_registers(0, 1);
		send_request(CMD_FAULT, 0, 22'd16, 0);
		send_request(CMD_MARK, 0, 22'd17, 0);
		wait_idle();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_registers(phase_pages[ph], phase_frames[ph]);
			if (ph == 1 || ph == 6) begin
				hold_off_req = 1'b1;
			end
			run_random(PHASE_ITEMS);
			wait_idle();
		end

		total = 0;
		foreach (predictor.status_tally[i]) begin
			total += predictor.status_tally[i];
		end
		$display("tb: %0d requests over %0d register writes: %0d free loads, %0d clean, %0d dirty evictions",
			total, predictor.reg_writes, predictor.status_tally[ST_FREE],
			predictor.status_tally[ST_CLEAN], predictor.status_tally[ST_DIRTY]);
		$display("tb: %0d resident hits, %0d dirty marks, %0d rejected, final disk count %0d",
			predictor.status_tally[ST_RESIDENT], predictor.status_tally[ST_MARKED],
			predictor.status_tally[ST_BAD], predictor.disk_count);
		if (predictor.mismatches == 0 && predictor.unexpected == 0 &&
			predictor.expected_outcomes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
`default_nettype wire
